FILE: src/crc8pw_pkg.sv
`timescale 1ns / 1ps

package crc8pw_pkg;

  // Operation codes carried on the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_START_TICKS = 2'd0;
  localparam logic [1:0] REG_SHORT_TICKS = 2'd1;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd2;

  // Reset values of the phase lengths
  localparam logic [7:0] START_TICKS_RST = 8'd64;
  localparam logic [7:0] SHORT_TICKS_RST = 8'd32;
  localparam logic [7:0] LONG_TICKS_RST  = 8'd96;

  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] STATUS_MASK = 8'h3f;

  // Phases 0..2 are start phases, 3..82 carry the 40 frame bits
  localparam int unsigned FRAME_BITS   = 40;
  localparam logic [6:0]  START_PHASES = 7'd3;
  localparam logic [6:0]  LAST_PHASE   = 7'd82;

  // One byte through the augmented CRC register, MSB first
  function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       top;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      top = r[7];
      r   = {r[6:0], data[i]};
      if (top) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/crc8_pulse_width_frame_transmitter_unit.sv
`timescale 1ns / 1ps

// Single-wire pulse-width frame transmitter with CRC-8 (poly 0x31).
// Input stream: tuser is the operation (0 load, 1 tick); tdata carries the
// four raw reading bytes. A load while idle builds a 40-bit frame (bytes plus
// CRC); a load while busy is dropped and flagged. Each tick while busy advances the
// frame timing: three start phases, then a low/high phase pair per bit.
// Output stream: one transaction per input transaction, giving the line
// level, busy and load-ignored flags; tlast marks the tick ending the frame.
// Throughput is one transaction per cycle unless the receiver stalls; the
// result appears in the cycle after acceptance, in the single output register.
// The phase logic feeds that register; the CRC logic feeds the frame register.
// When the receiver stalls, the output register holds its result and the
// input is only taken while that register is empty or being drained.
// Reset returns the line to idle high, clears the frame state and loads
// the default phase lengths (64, 32, 96 ticks). Config writes land at once.
module crc8_pulse_width_frame_transmitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cap_high_byte, cap_low_byte, temp_high_byte, temp_low_byte
  input  logic        s_axis_tuser,  // operation
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // line_level, busy_res, load_ignored, zero pad
  output logic        m_axis_tlast   // frame_done
);
  import crc8pw_pkg::*;

  logic [7:0] start_ticks_q, short_ticks_q, long_ticks_q;

  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [6:0]            phase_q, phase_d;
  logic [7:0]            cnt_q, cnt_d;
  logic                  line_q, line_d;
  logic                  busy_q, busy_d;

  logic       out_valid_q;
  logic [2:0] out_flags_q;
  logic       out_last_q;

  logic       accept;
  logic       done, ignored;
  logic [7:0] b0, b1, b2, b3, crc;
  logic [7:0] len_raw, len;
  logic [8:0] cnt_inc;
  logic       bit_one, low_half;
  logic [6:0] phase_inc;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ticks_q <= START_TICKS_RST;
      short_ticks_q <= SHORT_TICKS_RST;
      long_ticks_q  <= LONG_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_TICKS: start_ticks_q <= cfg_data_i;
        REG_SHORT_TICKS: short_ticks_q <= cfg_data_i;
        REG_LONG_TICKS:  long_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame contents and CRC for a load
  assign b0  = s_axis_tdata[7:0] & STATUS_MASK;
  assign b1  = s_axis_tdata[15:8];
  assign b2  = s_axis_tdata[23:16];
  assign b3  = s_axis_tdata[31:24];
  assign crc = crc_shift_byte(crc_shift_byte(crc_shift_byte(crc_shift_byte(b0, b1), b2), b3),
                              8'h00);

  // Length of the current phase; a zero setting counts as one tick
  assign bit_one  = frame_q[FRAME_BITS-1];
  assign low_half = phase_q[0];  // bit phases: odd index is the low half
  always_comb begin
    if (phase_q < START_PHASES) begin
      len_raw = start_ticks_q;
    end else if (bit_one == low_half) begin
      len_raw = short_ticks_q;
    end else begin
      len_raw = long_ticks_q;
    end
    len = (len_raw == 8'd0) ? 8'd1 : len_raw;
  end

  assign cnt_inc   = {1'b0, cnt_q} + 9'd1;
  assign phase_inc = phase_q + 7'd1;

  // Next state for one transaction
  always_comb begin
    frame_d = frame_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    busy_d  = busy_q;
    done    = 1'b0;
    ignored = 1'b0;
    if (s_axis_tuser == OP_LOAD) begin
      if (busy_q) begin
        ignored = 1'b1;
      end else begin
        frame_d = {b0, b1, b2, b3, crc};
        phase_d = '0;
        cnt_d   = '0;
        line_d  = 1'b1;
        busy_d  = 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_inc >= {1'b0, len}) begin
        // high half of a bit ends: move to the next bit
        if (phase_q >= START_PHASES && !phase_q[0]) begin
          frame_d = {frame_q[FRAME_BITS-2:0], 1'b0};
        end
        cnt_d = '0;
        if (phase_q == LAST_PHASE) begin
          busy_d  = 1'b0;
          line_d  = 1'b1;
          phase_d = '0;
          done    = 1'b1;
        end else begin
          phase_d = phase_inc;
          line_d  = !phase_inc[0];
        end
      end else begin
        cnt_d = cnt_inc[7:0];
      end
    end
  end

  // Transmitter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
      line_q  <= 1'b1;
      busy_q  <= 1'b0;
    end else if (accept) begin
      frame_q <= frame_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      busy_q  <= busy_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_flags_q <= {ignored, busy_d, line_d};
      out_last_q  <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_flags_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: src/crc8pw_checker.sv
`timescale 1ns / 1ps

module crc8pw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Frame end leaves the line idle high and the block not busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("frame end with line low or still busy");

  // A load is only dropped while a frame is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && !m_axis_tlast)
    else $error("load dropped while idle");

  // The line idles high whenever no frame is being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("line low while idle");

  // Pad bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0)
    else $error("nonzero pad bits");

endmodule

bind crc8_pulse_width_frame_transmitter_unit crc8pw_checker u_crc8pw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
